// ----- src/fqrf_pkg.sv -----
// ----------------------------------------------------------------------------
// FIFO queue with rotate and flip: shared definitions
// Request codes, default sizes and the operation flags that the controller
// hands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fqrf_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int REQ_W          = 3;

   localparam logic [REQ_W-1:0] REQ_ENQUEUE = 3'd0;
   localparam logic [REQ_W-1:0] REQ_DEQUEUE = 3'd1;
   localparam logic [REQ_W-1:0] REQ_ROTATE  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_FLIP    = 3'd3;
   localparam logic [REQ_W-1:0] REQ_SIZE    = 3'd4;

   typedef struct packed {
      logic ok;
      logic deq;
      logic enq_wr;
      logic rot_wr;
   } fqrf_op_type;

endpackage

`default_nettype wire

// ----- src/fqrf_ctrl.sv -----
// ----------------------------------------------------------------------------
// FIFO queue with rotate and flip: pointer controller
// Holds the front index, the word count and the direction flag, and works
// out the ring addresses and status of each request.
// ----------------------------------------------------------------------------
`default_nettype none

module fqrf_ctrl #(
   parameter int DEPTH = fqrf_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [fqrf_pkg::REQ_W-1:0]      req_type,
   output logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic [$clog2(DEPTH)-1:0]        wr_addr,
   output fqrf_pkg::fqrf_op_type           op,
   output logic [$clog2(DEPTH+1)-1:0]      count_next
);
   import fqrf_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
   localparam logic [IDX_W-1:0] POS_ONE = IDX_W'(1);

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             reversed_ff, reversed_in;
   logic [IDX_W-1:0] cnt_pos;
   logic [CNT_W-1:0] cnt_m1;
   logic [IDX_W-1:0] back_slot;
   logic [IDX_W-1:0] next_slot;
   logic [IDX_W-1:0] last_slot;

   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                                input logic [IDX_W-1:0] pos,
                                                input logic             rev);
      logic [IDX_W:0] sum;
      if (rev) begin
         sum = {1'b0, front} + DEPTH_X - {1'b0, pos};
      end else begin
         sum = {1'b0, front} + {1'b0, pos};
      end
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return sum[IDX_W-1:0];
   endfunction

   always_comb begin
      cnt_pos   = (count_ff == DEPTH_C) ? '0 : count_ff[IDX_W-1:0];
      cnt_m1    = count_ff - CNT_ONE;
      back_slot = slot_of(front_ff, cnt_pos, reversed_ff);
      next_slot = slot_of(front_ff, POS_ONE, reversed_ff);
      last_slot = slot_of(front_ff, cnt_m1[IDX_W-1:0], reversed_ff);

      front_in    = front_ff;
      count_in    = count_ff;
      reversed_in = reversed_ff;
      op          = '{ok: 1'b1, deq: 1'b0, enq_wr: 1'b0, rot_wr: 1'b0};

      case (req_type)
         REQ_ENQUEUE: begin
            if (count_ff == DEPTH_C) begin
               op.ok = 1'b0;
            end else begin
               op.enq_wr = 1'b1;
               count_in  = count_ff + CNT_ONE;
            end
         end
         REQ_DEQUEUE: begin
            if (count_ff == '0) begin
               op.ok = 1'b0;
            end else begin
               op.deq   = 1'b1;
               front_in = next_slot;
               count_in = cnt_m1;
            end
         end
         REQ_ROTATE: begin
            if (count_ff >= CNT_TWO) begin
               op.rot_wr = 1'b1;
               front_in  = next_slot;
            end
         end
         REQ_FLIP: begin
            if (count_ff >= CNT_TWO) begin
               front_in    = last_slot;
               reversed_in = !reversed_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rd_addr    = front_ff;
   assign wr_addr    = back_slot;
   assign count_next = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff    <= '0;
         count_ff    <= '0;
         reversed_ff <= 1'b0;
      end else if (accept) begin
         front_ff    <= front_in;
         count_ff    <= count_in;
         reversed_ff <= reversed_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("word count exceeds the ring depth");

   a_enq_counts_up: assert property (@(posedge clock) disable iff (reset)
      accept && op.enq_wr |=> count_ff == $past(count_ff) + CNT_ONE)
      else $error("successful enqueue did not add one word");

   a_fail_holds_front: assert property (@(posedge clock) disable iff (reset)
      accept && !op.ok |=> front_ff == $past(front_ff) && count_ff == $past(count_ff))
      else $error("failed request changed the queue");

endmodule

`default_nettype wire

// ----- src/fqrf_ring.sv -----
// ----------------------------------------------------------------------------
// FIFO queue with rotate and flip: ring store
// Word memory with a registered read port, one write port and a bypass for
// a write that lands on the address being read in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fqrf_ring #(
   parameter int DEPTH      = fqrf_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = fqrf_pkg::DATA_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   input  logic                       wr_en,
   input  logic                       wr_rotate,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_WIDTH-1:0]      wr_word,
   output logic [DATA_WIDTH-1:0]      rd_data
);
   import fqrf_pkg::*;

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_ff;
   logic [DATA_WIDTH-1:0] byp_data_ff;
   logic                  byp_valid_ff;
   logic [DATA_WIDTH-1:0] wdata;

   assign rd_data = byp_valid_ff ? byp_data_ff : rd_ff;
   assign wdata   = wr_rotate ? rd_data : wr_word;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wdata;
      end
      if (rd_en) begin
         rd_ff        <= mem[rd_addr];
         byp_valid_ff <= wr_en && (wr_addr == rd_addr);
         byp_data_ff  <= wdata;
      end
   end

endmodule

`default_nettype wire

// ----- src/fifo_queue_rotate_flip.sv -----
// ----------------------------------------------------------------------------
// FIFO queue with rotate and flip
// Ring-buffered word queue with enqueue, dequeue, rotate, flip and size
// requests; every request transaction yields one result transaction.
//
//   Channel | Direction | tdata                      | tuser
//   req     | in        | data_in                    | req_type
//   rsp     | out       | data_out, item_count       | ok
//
// One request transaction is taken per cycle unless a stall holds req_tready
// low; its result passes through the middle stage and the output register.
// Reset clears the pointers and the count; the ring contents are not
// cleared and need no clearing pass.
// A stalled result holds in the output register while one more request is
// taken into the middle stage; after that req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_queue_rotate_flip #(
   parameter  int DEPTH       = fqrf_pkg::DEPTH_DEF,
   parameter  int DATA_WIDTH  = fqrf_pkg::DATA_WIDTH_DEF,
   localparam int CNT_W       = $clog2(DEPTH + 1),
   localparam int IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8,
   localparam int OUT_TDATA_W = ((DATA_WIDTH + CNT_W + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [IN_TDATA_W-1:0]          req_tdata,   // data_in
   input  logic [fqrf_pkg::REQ_W-1:0]     req_tuser,   // req_type
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [OUT_TDATA_W-1:0]         rsp_tdata,   // data_out, item_count
   output logic                           rsp_tuser    // ok
);
   import fqrf_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   logic                  accept;
   logic                  s1_advance;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      wr_addr;
   fqrf_op_type           op;
   logic [CNT_W-1:0]      count_next;
   logic [DATA_WIDTH-1:0] rd_data;

   logic                  s1_valid_ff, s1_valid_in;
   fqrf_op_type           s1_op_ff;
   logic [IDX_W-1:0]      s1_waddr_ff;
   logic [DATA_WIDTH-1:0] s1_word_ff;
   logic [CNT_W-1:0]      s1_count_ff;

   logic                  out_valid_ff, out_valid_in;
   logic                  out_ok_ff;
   logic [DATA_WIDTH-1:0] out_data_ff;
   logic [CNT_W-1:0]      out_count_ff;

   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign accept     = req_tvalid && req_tready;

   fqrf_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_type  (req_tuser),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .op        (op),
      .count_next(count_next)
   );

   fqrf_ring #(
      .DEPTH     (DEPTH),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_ring (
      .clock    (clock),
      .rd_en    (accept),
      .rd_addr  (rd_addr),
      .wr_en    (s1_advance && (s1_op_ff.enq_wr || s1_op_ff.rot_wr)),
      .wr_rotate(s1_op_ff.rot_wr),
      .wr_addr  (s1_waddr_ff),
      .wr_word  (s1_word_ff),
      .rd_data  (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= op;
         s1_waddr_ff <= wr_addr;
         s1_word_ff  <= req_tdata[DATA_WIDTH-1:0];
         s1_count_ff <= count_next;
      end
      if (s1_advance) begin
         out_ok_ff    <= s1_op_ff.ok;
         out_data_ff  <= s1_op_ff.deq ? rd_data : '0;
         out_count_ff <= s1_count_ff;
      end
   end

   always_comb begin
      rsp_tdata                       = '0;
      rsp_tdata[DATA_WIDTH-1:0]       = out_data_ff;
      rsp_tdata[DATA_WIDTH +: CNT_W]  = out_count_ff;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ok_ff;

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while both stages are full and stalled");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the FIFO queue with rotate and flip
// Sends enqueue, dequeue, rotate, flip, size and unused-code request
// transactions. A short directed sequence comes first, then random segments
// that push the queue toward full, toward empty or keep it balanced. Each
// accepted request is run through a shadow copy of the ring queue, and every
// result transaction is compared field by field with the oldest predicted
// result. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb_top;

   import fqrf_pkg::*;

   localparam int DEPTH          = DEPTH_DEF;
   localparam int DATA_W         = DATA_WIDTH_DEF;
   localparam int CNT_W          = $clog2(DEPTH + 1);
   localparam int IN_W           = ((DATA_W + 7) / 8) * 8;
   localparam int OUT_W          = ((DATA_W + CNT_W + 7) / 8) * 8;
   localparam int RANDOM_ITEMS   = 1550;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MODE_PERIOD    = 200;

   localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

   typedef struct {
      logic [REQ_W-1:0]  kind;
      logic [DATA_W-1:0] word;
   } queue_request_type;

   typedef struct {
      logic              ok;
      logic [DATA_W-1:0] data;
      logic [CNT_W-1:0]  count;
   } queue_result_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [IN_W-1:0]    req_tdata  = '0;
   logic [REQ_W-1:0]   req_tuser  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [OUT_W-1:0]   rsp_tdata;
   logic               rsp_tuser;

   queue_request_type  pending_requests[$];
   queue_result_type   due_results[$];
   int                 mismatch_count = 0;

   logic [DATA_W-1:0]  shadow_ring [DEPTH];
   int                 shadow_front    = 0;
   int                 shadow_count    = 0;
   logic               shadow_reversed = 1'b0;

   int                 send_gap   = 0;
   int                 send_ticks = 0;
   bit                 send_calm  = 1'b0;
   int                 stall_left = 0;
   int                 recv_ticks = 0;
   bit                 recv_calm  = 1'b0;
   int                 idle_cycles = 0;

   fifo_queue_rotate_flip i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int slot_at(int pos);
      int p;
      p = pos % DEPTH;
      if (shadow_reversed) return (shadow_front + DEPTH - p) % DEPTH;
      return (shadow_front + p) % DEPTH;
   endfunction

   task automatic predict_queue_op(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] word);
      queue_result_type res;
      res.ok   = 1'b1;
      res.data = '0;
      case (kind)
         REQ_ENQUEUE: begin
            if (shadow_count >= DEPTH) begin
               res.ok = 1'b0;
            end else begin
               shadow_ring[slot_at(shadow_count)] = word;
               shadow_count++;
            end
         end
         REQ_DEQUEUE: begin
            if (shadow_count == 0) begin
               res.ok = 1'b0;
            end else begin
               res.data     = shadow_ring[shadow_front];
               shadow_front = slot_at(1);
               shadow_count--;
            end
         end
         REQ_ROTATE: begin
            if (shadow_count >= 2) begin
               shadow_ring[slot_at(shadow_count)] = shadow_ring[shadow_front];
               shadow_front = slot_at(1);
            end
         end
         REQ_FLIP: begin
            if (shadow_count >= 2) begin
               shadow_front    = slot_at(shadow_count - 1);
               shadow_reversed = !shadow_reversed;
            end
         end
         default: begin
         end
      endcase
      res.count = shadow_count[CNT_W-1:0];
      due_results.push_back(res);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic add_request(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] word);
      queue_request_type item;
      item.kind = kind;
      item.word = word;
      pending_requests.push_back(item);
   endtask

   function automatic logic [DATA_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 32'h1 << $urandom_range(0, DATA_W - 1);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [REQ_W-1:0] random_kind(int enq_pct);
      int s;
      if ($urandom_range(0, 99) < enq_pct) return REQ_ENQUEUE;
      s = $urandom_range(0, 19);
      if (s <= 8) return REQ_DEQUEUE;
      if (s <= 12) return REQ_ROTATE;
      if (s <= 15) return REQ_FLIP;
      if (s <= 17) return REQ_SIZE;
      return REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
   endfunction

   // The driver sends queued requests with random gaps between them.
   always @(posedge clock) begin
      queue_request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         send_ticks++;
         if (send_ticks % MODE_PERIOD == 0) send_calm = ($urandom_range(0, 3) == 0);
         if (req_tvalid && req_tready) predict_queue_op(req_tuser, req_tdata[DATA_W-1:0]);
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               nxt = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.kind;
               req_tdata  <= IN_W'(nxt.word);
               send_gap = pick_gap(send_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // The monitor checks each result transaction and stalls at random.
   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         recv_ticks++;
         if (recv_ticks % MODE_PERIOD == 0) recv_calm = ($urandom_range(0, 3) == 0);
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               report_mismatch("result transaction with none outstanding",
                               64'(rsp_tdata), 64'd0);
            end else begin
               want = due_results.pop_front();
               if (rsp_tuser !== want.ok)
                  report_mismatch("ok flag", 64'(rsp_tuser), 64'(want.ok));
               if (rsp_tdata[DATA_W-1:0] !== want.data)
                  report_mismatch("data_out", 64'(rsp_tdata[DATA_W-1:0]), 64'(want.data));
               if (rsp_tdata[DATA_W +: CNT_W] !== want.count)
                  report_mismatch("item_count", 64'(rsp_tdata[DATA_W +: CNT_W]),
                                  64'(want.count));
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap(recv_calm);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("Test completed with failures");
               $finish;
            end
         end
      end
   end

   initial begin
      int produced;
      int seg_len;
      int enq_pct;

      // The directed part covers the empty queue, a single word, unused codes and a full queue.
      add_request(REQ_DEQUEUE, '1);
      add_request(REQ_ROTATE, '0);
      add_request(REQ_ENQUEUE, '0);
      add_request(REQ_FLIP, '1);
      add_request(REQ_UNUSED_LO, $urandom);
      add_request(REQ_UNUSED_HI, $urandom);
      add_request(REQ_ENQUEUE, '1);
      add_request(REQ_FLIP, '0);
      for (int i = 0; i < DEPTH - 2; i++) add_request(REQ_ENQUEUE, random_word());
      add_request(REQ_ENQUEUE, 32'hA5A5_5A5A);
      add_request(REQ_ROTATE, '0);
      add_request(REQ_FLIP, '0);
      add_request(REQ_SIZE, '1);
      add_request(REQ_DEQUEUE, '0);

      // Each random segment is picked at random as a filling, draining or balanced mix.
      produced = 0;
      while (produced < RANDOM_ITEMS) begin
         seg_len = $urandom_range(10, 60);
         case ($urandom_range(0, 2))
            0: enq_pct = 70;
            1: enq_pct = 25;
            default: enq_pct = 45;
         endcase
         for (int i = 0; i < seg_len; i++) add_request(random_kind(enq_pct), random_word());
         produced += seg_len;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (pending_requests.size() != 0 || req_tvalid || due_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
